@@ hdl/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants of the command frame checker
// Byte roles, error codes, parser phases, the result bundle and the frame
// prefix lookup.
// ----------------------------------------------------------------------------
package cfc_pkg;

  // Header layout
  localparam logic [15:0] HDR_LEN     = 16'd10;
  localparam logic [15:0] MIN_VAR_LEN = 16'd4;
  localparam logic [15:0] PREFIX_LEN  = 16'd4;

  // Byte positions inside the header
  localparam logic [3:0] POS_SLOT_HI  = 4'd4;
  localparam logic [3:0] POS_SLOT_LO  = 4'd5;
  localparam logic [3:0] POS_TIMEOUT  = 4'd6;
  localparam logic [3:0] POS_INTERVAL = 4'd7;
  localparam logic [3:0] POS_LEN_HI   = 4'd8;

  // Role of each byte in the frame
  typedef enum logic [2:0] {
    ROLE_PREFIX    = 3'd0,
    ROLE_HEADER    = 3'd1,
    ROLE_COUNT     = 3'd2,
    ROLE_ARG_BYTE  = 3'd3,
    ROLE_ARG_NUL   = 3'd4,
    ROLE_DESC_BYTE = 3'd5,
    ROLE_DESC_NUL  = 3'd6,
    ROLE_EXTRA     = 3'd7
  } role_e;

  // Frame error codes
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_PREFIX    = 3'd1,
    ERR_SHORT     = 3'd2,
    ERR_ZERO_ARGS = 3'd3,
    ERR_NO_TERM   = 3'd4,
    ERR_TRAILING  = 3'd5
  } err_e;

  // Parser phase, one-hot
  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_VAR    = 2'b10
  } phase_e;

  // One result item
  typedef struct packed {
    logic [7:0]  byte_out;
    role_e       role;
    logic [7:0]  arg_number;
    logic [15:0] slot_index;
    logic [7:0]  timeout_val;
    logic [7:0]  interval_val;
    logic [7:0]  arg_total;
    logic        frame_end;
    err_e        error_code;
  } result_t;

  // Expected prefix text "CMD:"
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h43;
      2'd1:    ch = 8'h4D;
      2'd2:    ch = 8'h44;
      default: ch = 8'h3A;
    endcase
    return ch;
  endfunction

endpackage

@@ hdl/cfc_parser.sv @@
// ----------------------------------------------------------------------------
// cfc_parser: frame state and per-byte classification
// Holds the frame parsing state and computes the result of one byte in a
// single combinational pass; state advances when take_i is high.
// ----------------------------------------------------------------------------
module cfc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output cfc_pkg::result_t  result_o
);

  cfc_pkg::phase_e phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] sec_len_q, sec_len_d;
  logic        prefix_ok_q, prefix_ok_d;
  logic [15:0] slot_q, slot_d;
  logic [7:0]  timeout_q, timeout_d;
  logic [7:0]  interval_q, interval_d;
  logic [7:0]  arg_total_q, arg_total_d;
  logic [8:0]  nul_cnt_q, nul_cnt_d;
  cfc_pkg::err_e pend_err_q, pend_err_d;

  cfc_pkg::role_e role;
  cfc_pkg::err_e  err;
  logic [7:0]     arg_num;
  logic           fend;
  logic           var_last;

  // Last byte of the variable section
  assign var_last = ({1'b0, pos_q} + 17'd1) >= {1'b0, sec_len_q};

  // Classify the byte and compute next state
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sec_len_d   = sec_len_q;
    prefix_ok_d = prefix_ok_q;
    slot_d      = slot_q;
    timeout_d   = timeout_q;
    interval_d  = interval_q;
    arg_total_d = arg_total_q;
    nul_cnt_d   = nul_cnt_q;
    pend_err_d  = pend_err_q;
    role        = cfc_pkg::ROLE_PREFIX;
    err         = cfc_pkg::ERR_OK;
    arg_num     = 8'd0;
    fend        = 1'b0;

    if (phase_q == cfc_pkg::PH_HEADER) begin
      if (pos_q < cfc_pkg::PREFIX_LEN) begin
        role = cfc_pkg::ROLE_PREFIX;
        if (byte_i != cfc_pkg::prefix_char(pos_q[1:0])) begin
          prefix_ok_d = 1'b0;
        end
      end else begin
        role = cfc_pkg::ROLE_HEADER;
        case (pos_q[3:0])
          cfc_pkg::POS_SLOT_HI:  slot_d[15:8]    = byte_i;
          cfc_pkg::POS_SLOT_LO:  slot_d[7:0]     = byte_i;
          cfc_pkg::POS_TIMEOUT:  timeout_d       = byte_i;
          cfc_pkg::POS_INTERVAL: interval_d      = byte_i;
          cfc_pkg::POS_LEN_HI:   sec_len_d[15:8] = byte_i;
          default:               sec_len_d[7:0]  = byte_i;
        endcase
      end
      // Check the header on its last byte
      if (pos_q == (cfc_pkg::HDR_LEN - 16'd1)) begin
        if (!prefix_ok_d) begin
          fend = 1'b1;
          err  = cfc_pkg::ERR_PREFIX;
        end else if (sec_len_d < cfc_pkg::MIN_VAR_LEN) begin
          fend = 1'b1;
          err  = cfc_pkg::ERR_SHORT;
        end else begin
          phase_d = cfc_pkg::PH_VAR;
        end
        pos_d       = 16'd0;
        nul_cnt_d   = fend ? nul_cnt_q : 9'd0;
        pend_err_d  = cfc_pkg::ERR_OK;
        prefix_ok_d = fend ? 1'b1 : prefix_ok_d;
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end else begin
      if (pos_q == 16'd0) begin
        role        = cfc_pkg::ROLE_COUNT;
        arg_total_d = byte_i;
        if (byte_i == 8'd0) begin
          pend_err_d = cfc_pkg::ERR_ZERO_ARGS;
        end
      end else if (nul_cnt_q < {1'b0, arg_total_q}) begin
        arg_num = nul_cnt_q[7:0];
        if (byte_i != 8'd0) begin
          role = cfc_pkg::ROLE_ARG_BYTE;
        end else begin
          role      = cfc_pkg::ROLE_ARG_NUL;
          nul_cnt_d = nul_cnt_q + 9'd1;
        end
      end else if (nul_cnt_q == {1'b0, arg_total_q}) begin
        if (byte_i != 8'd0) begin
          role = cfc_pkg::ROLE_DESC_BYTE;
        end else begin
          role      = cfc_pkg::ROLE_DESC_NUL;
          nul_cnt_d = nul_cnt_q + 9'd1;
        end
      end else begin
        role = cfc_pkg::ROLE_EXTRA;
        if (pend_err_q == cfc_pkg::ERR_OK) begin
          pend_err_d = cfc_pkg::ERR_TRAILING;
        end
      end
      // Close the frame on the last section byte
      if (var_last) begin
        if (pend_err_d == cfc_pkg::ERR_OK && nul_cnt_d <= {1'b0, arg_total_d}) begin
          pend_err_d = cfc_pkg::ERR_NO_TERM;
        end
        fend        = 1'b1;
        err         = pend_err_d;
        phase_d     = cfc_pkg::PH_HEADER;
        pos_d       = 16'd0;
        prefix_ok_d = 1'b1;
        pend_err_d  = cfc_pkg::ERR_OK;
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  // Assemble the result with held values after this byte
  always_comb begin
    result_o.byte_out     = byte_i;
    result_o.role         = role;
    result_o.arg_number   = arg_num;
    result_o.slot_index   = slot_d;
    result_o.timeout_val  = timeout_d;
    result_o.interval_val = interval_d;
    result_o.arg_total    = arg_total_d;
    result_o.frame_end    = fend;
    result_o.error_code   = err;
  end

  // Advance state on each taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfc_pkg::PH_HEADER;
      pos_q       <= 16'd0;
      sec_len_q   <= 16'd0;
      prefix_ok_q <= 1'b1;
      slot_q      <= 16'd0;
      timeout_q   <= 8'd0;
      interval_q  <= 8'd0;
      arg_total_q <= 8'd0;
      nul_cnt_q   <= 9'd0;
      pend_err_q  <= cfc_pkg::ERR_OK;
    end else if (take_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      sec_len_q   <= sec_len_d;
      prefix_ok_q <= prefix_ok_d;
      slot_q      <= slot_d;
      timeout_q   <= timeout_d;
      interval_q  <= interval_d;
      arg_total_q <= arg_total_d;
      nul_cnt_q   <= nul_cnt_d;
      pend_err_q  <= pend_err_d;
    end
  end

endmodule

@@ hdl/command_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// command_frame_checker_top: byte stream command frame checker
// Tags every byte of a command frame with its role, shows held header
// fields and reports frame errors on the final byte of each frame.
// ----------------------------------------------------------------------------
// Output: a result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one byte per cycle; the output register refills in the same
// cycle it is drained, so the input only stalls while the output is stalled.
// Reset: rst_ni clears the parser to header search and empties the output.
// ----------------------------------------------------------------------------
module command_frame_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_out, [15:8] arg_number, [31:16] slot_index,
  // [39:32] timeout_val, [47:40] interval_val, [55:48] arg_total,
  // [58:56] error_code, [63:59] zero
  output logic [63:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] role
  output logic        m_axis_tlast    // frame_end
);

  logic             take;
  logic             out_valid_q;
  cfc_pkg::result_t res_d;
  cfc_pkg::result_t res_q;

  // Accept when the output register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  cfc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (s_axis_tdata),
    .result_o (res_d)
  );

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  // Drive the output item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.role;
  assign m_axis_tlast  = res_q.frame_end;
  assign m_axis_tdata  = {5'd0, res_q.error_code, res_q.arg_total, res_q.interval_val,
                          res_q.timeout_val, res_q.slot_index, res_q.arg_number,
                          res_q.byte_out};

  // An error is only reported on the last byte of a frame
  a_err_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> res_q.error_code == cfc_pkg::ERR_OK)
    else $error("error code without frame end");

  // Header errors land on a header byte
  a_hdr_err_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.error_code == cfc_pkg::ERR_PREFIX ||
                      res_q.error_code == cfc_pkg::ERR_SHORT)
    |-> res_q.role == cfc_pkg::ROLE_HEADER)
    else $error("header error on a non-header byte");

  // Argument number is zero outside argument bytes
  a_argn_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.role != cfc_pkg::ROLE_ARG_BYTE &&
    res_q.role != cfc_pkg::ROLE_ARG_NUL |-> res_q.arg_number == 8'd0)
    else $error("argument number outside argument bytes");

  // An accepted item shows up at the output next cycle
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> m_axis_tvalid)
    else $error("accepted item did not reach the output");

endmodule
